### rtl/mpfb_pkg.sv
// Shared constants and controller/datapath interface types for the page frame buffer.
`timescale 1ns / 1ps

package mpfb_pkg;

    // Panel geometry.
    localparam int WIDTH  = 128;
    localparam int HEIGHT = 64;

    // Frame store geometry.
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(WIDTH + 1);

    // Operation codes carried on the mode input.
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // Pixel write modes held in the draw colour register.
    localparam logic [1:0] COLOR_SET    = 2'd0;
    localparam logic [1:0] COLOR_CLEAR  = 2'd1;
    localparam logic [1:0] COLOR_INVERT = 2'd2;

    // Panel command bytes sent ahead of each page.
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h02;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted item
        logic draw_wr;    // write back the modified pixel byte
        logic clr_wr;     // zero one store entry and advance the sweep
        logic emit_cmd;   // present the page command result
        logic flush_rd;   // read the byte at the current flush column
        logic flush_acc;  // pack the byte just read into the current group
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_draw_ok; // offered item is an on-screen draw
        logic in_clear;   // offered item is a clear
        logic in_flush;   // offered item is a flush
        logic clr_done;   // sweep is at the final entry
        logic last_col;   // flush is at the final column
    } t_dp_sts;

endpackage

### rtl/mpfb_ctrl.sv
// Controller state machine sequencing draw, clear and flush operations.
`timescale 1ns / 1ps

module mpfb_ctrl
    import mpfb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW_WR,
        S_FLUSH_CMD,
        S_FLUSH_RD,
        S_FLUSH_ACC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    priority if (i_sts.in_draw_ok) begin
                        n_state = S_DRAW_WR;
                    end else if (i_sts.in_clear) begin
                        n_state = S_CLEAR;
                    end else if (i_sts.in_flush) begin
                        n_state = S_FLUSH_CMD;
                    end else begin
                        // Off-screen draws and the spare mode are dropped.
                        n_state = S_IDLE;
                    end
                end
            end
            S_DRAW_WR: begin
                o_cmd.draw_wr = 1'b1;
                n_state       = S_IDLE;
            end
            S_FLUSH_CMD: begin
                o_cmd.emit_cmd = 1'b1;
                n_state        = S_FLUSH_RD;
            end
            S_FLUSH_RD: begin
                o_cmd.flush_rd = 1'b1;
                n_state        = S_FLUSH_ACC;
            end
            S_FLUSH_ACC: begin
                o_cmd.flush_acc = 1'b1;
                n_state         = i_sts.last_col ? S_IDLE : S_FLUSH_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts with a sweep that zeroes the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/mpfb_datapath.sv
// Frame store memory, address counters, pixel update and result assembly.
`timescale 1ns / 1ps

module mpfb_datapath
    import mpfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [2:0]  i_page,
    output logic        o_valid,
    output logic        o_is_command,
    output logic [2:0]  o_byte_count,
    output logic [31:0] o_payload,
    output logic        o_last_of_run
);

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rd_data;
    logic [1:0]        r_color;
    logic [ADDR_W-1:0] r_draw_addr;
    logic [7:0]        r_mask;
    logic [2:0]        r_page;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [COL_W-1:0]  r_col;
    logic [2:0]        r_cnt;
    logic [31:0]       r_pay;
    logic              r_out_valid;
    logic              r_out_cmd;
    logic [2:0]        r_out_count;
    logic [31:0]       r_out_payload;
    logic              r_out_last;

    logic [ADDR_W-1:0] in_draw_addr;
    logic [ADDR_W-1:0] flush_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        pix_byte;
    logic              mem_we;
    logic [31:0]       n_pay;
    logic              group_end;

    // Decode of the offered item.
    assign o_sts.in_draw_ok = (i_mode == MODE_DRAW) && (32'(i_x) < WIDTH)
                              && (32'(i_y) < HEIGHT);
    assign o_sts.in_clear   = (i_mode == MODE_CLEAR);
    assign o_sts.in_flush   = (i_mode == MODE_FLUSH);
    assign o_sts.clr_done   = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
    assign o_sts.last_col   = (r_col == COL_W'(WIDTH - 1));

    // Store addresses: byte (page * WIDTH + column).
    assign in_draw_addr = ADDR_W'(32'(i_y[7:3]) * WIDTH + 32'(i_x));
    assign flush_addr   = ADDR_W'(32'(r_page) * WIDTH + 32'(r_col));
    assign rd_addr      = i_cmd.flush_rd ? flush_addr : in_draw_addr;

    // Pixel update on the byte read during the accept cycle.
    always_comb begin
        unique case (r_color)
            COLOR_SET:    pix_byte = r_rd_data | r_mask;
            COLOR_CLEAR:  pix_byte = r_rd_data & ~r_mask;
            COLOR_INVERT: pix_byte = r_rd_data ^ r_mask;
            default:      pix_byte = r_rd_data;
        endcase
    end

    assign mem_we  = i_cmd.draw_wr || i_cmd.clr_wr;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_draw_addr;
    assign wr_data = i_cmd.clr_wr ? 8'h00 : pix_byte;

    // Frame store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Byte packing for the current data group.
    always_comb begin
        n_pay = r_pay;
        n_pay[8 * r_cnt[1:0] +: 8] = r_rd_data;
    end
    assign group_end = (r_cnt == 3'd3) || o_sts.last_col;

    // Draw colour register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_SET;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    // Captured item fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_draw_addr <= in_draw_addr;
            r_mask      <= 8'h01 << i_y[2:0];
            r_page      <= i_page;
        end
    end

    // Clear sweep counter; it wraps to zero at the end of each pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Flush column and group counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_col <= '0;
            r_cnt <= '0;
        end else if (i_cmd.flush_acc) begin
            r_col <= r_col + 1'b1;
            r_cnt <= group_end ? 3'd0 : r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pay <= '0;
        end else if (i_cmd.flush_acc) begin
            r_pay <= group_end ? 32'h0 : n_pay;
        end
    end

    // Result strobe: high for one cycle per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit_cmd || (i_cmd.flush_acc && group_end);
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cmd) begin
            r_out_cmd     <= 1'b1;
            r_out_count   <= 3'd3;
            r_out_payload <= {8'h00, CMD_COL_HIGH, CMD_COL_LOW,
                              CMD_PAGE_BASE + {5'd0, r_page}};
            r_out_last    <= 1'b0;
        end else if (i_cmd.flush_acc && group_end) begin
            r_out_cmd     <= 1'b0;
            r_out_count   <= r_cnt + 3'd1;
            r_out_payload <= n_pay;
            r_out_last    <= o_sts.last_col;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_command  = r_out_cmd;
    assign o_byte_count  = r_out_count;
    assign o_payload     = r_out_payload;
    assign o_last_of_run = r_out_last;

endmodule

### rtl/mono_page_framebuffer_core.sv
// Top level of the monochrome page frame buffer: controller plus datapath.
`timescale 1ns / 1ps
//
// Usage: offer an item on i_mode, i_x, i_y, i_page and raise start; the
// item is taken at the rising edge where start is high and busy is low.
// The draw colour register is written through i_cfg_data with i_cfg_valid;
// o_cfg_ready is always high, and writes belong in idle periods.
// Sequence of each operation, from the accepting edge until busy falls:
//   draw pixel:  read of the byte at accept, write-back in the next cycle.
//   clear store: all 1024 store entries, one zeroed per cycle on the write port.
//   flush page:  the page command, then for each of the WIDTH bytes a read
//                and a pack step through the single registered read port.
// Results of a flush appear on o_valid, each for exactly one cycle: the page
// command transfer first, then data transfers of up to four bytes, the last
// one marked by o_last_of_run. The receiver cannot stall; it must take each
// transfer in the cycle it is shown.
// After reset the store is zeroed by a sweep of all 1024 entries with busy high; the
// draw colour returns to set.

module mono_page_framebuffer_core
    import mpfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_x,
    input  logic [7:0]  i_y,
    input  logic [2:0]  i_page,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic        o_is_command,
    output logic [2:0]  o_byte_count,
    output logic [31:0] o_payload,
    output logic        o_last_of_run
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_we;

    // The colour register takes a transfer in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    mpfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    mpfb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_page        (i_page),
        .o_valid       (o_valid),
        .o_is_command  (o_is_command),
        .o_byte_count  (o_byte_count),
        .o_payload     (o_payload),
        .o_last_of_run (o_last_of_run)
    );

endmodule
